FILE: hw/rtl/dfir_pkg.sv
// ----------------------------------------------------------------------------
// dfir_pkg: shared definitions for the decimating FIR filter core
// Register widths and reset values, register indexes, sequencer states and
// the control bundle that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package dfir_pkg;

   // Default values of the top-level parameters.
   localparam int MAX_TAPS_DEF    = 1024;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 18;

   // Fixed field and register widths.
   localparam int RATIO_W      = 8;
   localparam int TAPS_REG_W   = 11;
   localparam int GAIN_W       = 16;
   localparam int COEF_INDEX_W = 10;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Register reset values.
   localparam logic [RATIO_W-1:0]    DECIM_RATIO_RST = RATIO_W'(24);
   localparam logic [TAPS_REG_W-1:0] TAPS_RST        = TAPS_REG_W'(745);
   localparam logic [GAIN_W-1:0]     GAIN_RST        = GAIN_W'(6554);

   // The gain multiply walks the accumulator in chunks of this many bits.
   localparam int CHUNK_W = 16;

   // Cycles between the last tap read and a settled accumulator.
   localparam int DRAIN_CYCLES = 2;
   localparam int DRAIN_W      = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DECIM_RATIO = 2'd0,
      CSR_TAPS_IN_USE = 2'd1,
      CSR_OUT_GAIN    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE,
      ST_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic clear;   // start of a new output: clear accumulator
      logic issue;   // a tap read is issued to both memories this cycle
      logic live;    // the issued delay-line entry holds a real sample
      logic scale;   // one step of the gain multiply
      logic emit;    // rounded result is on offer to the output register
   } mac_ctl_type;

endpackage

FILE: hw/rtl/dfir_ram.sv
// ----------------------------------------------------------------------------
// dfir_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dfir_ram #(
   parameter int DEPTH  = dfir_pkg::MAX_TAPS_DEF,
   parameter int WIDTH  = dfir_pkg::SAMPLE_BITS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/dfir_ctrl.sv
// ----------------------------------------------------------------------------
// dfir_ctrl: request sequencer of the decimating FIR filter
// Tracks the delay-line pointer, fill level, warmup and decimation phase,
// and walks the tap addresses through both memories for each output.
// ----------------------------------------------------------------------------
module dfir_ctrl #(
   parameter int  MAX_TAPS = dfir_pkg::MAX_TAPS_DEF,
   localparam int ADDR_W   = $clog2(MAX_TAPS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_type,
   input  logic [dfir_pkg::COEF_INDEX_W-1:0]  req_coef_index,
   input  logic [dfir_pkg::RATIO_W-1:0]       decim_ratio,
   input  logic [dfir_pkg::TAPS_REG_W-1:0]    taps_in_use,
   input  logic                               scale_last,
   input  logic                               out_free,
   output logic                               req_stall,
   output logic                               samp_we,
   output logic [ADDR_W-1:0]                  samp_waddr,
   output logic [ADDR_W-1:0]                  samp_raddr,
   output logic                               coef_we,
   output logic [ADDR_W-1:0]                  coef_waddr,
   output logic [ADDR_W-1:0]                  coef_raddr,
   output dfir_pkg::mac_ctl_type              ctl
);

   localparam int TAPS_W = $clog2(MAX_TAPS + 1);
   localparam int CLW    = (TAPS_W > dfir_pkg::TAPS_REG_W) ? TAPS_W : dfir_pkg::TAPS_REG_W;
   localparam int IXW    = (TAPS_W > dfir_pkg::COEF_INDEX_W) ? TAPS_W : dfir_pkg::COEF_INDEX_W;
   localparam int PH_W   = dfir_pkg::RATIO_W + 1;
   localparam logic [dfir_pkg::DRAIN_W-1:0] DRAIN_LAST =
      dfir_pkg::DRAIN_W'(dfir_pkg::DRAIN_CYCLES - 1);

   dfir_pkg::fsm_state_type state_ff, state_in;

   logic [ADDR_W-1:0]               wp_ff, wp_in;
   logic [TAPS_W-1:0]               fill_ff, fill_in;
   logic [ADDR_W-1:0]               warm_ff, warm_in;
   logic [dfir_pkg::RATIO_W-1:0]    phase_ff, phase_in;
   logic [ADDR_W-1:0]               m_ff, m_in;
   logic [ADDR_W-1:0]               last_m_ff, last_m_in;
   logic [ADDR_W-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [dfir_pkg::DRAIN_W-1:0]    dr_ff, dr_in;

   logic                            idle;
   logic                            take_sample;
   logic                            take_coef;
   logic [CLW-1:0]                  taps_ext;
   logic [CLW-1:0]                  taps_eff;
   logic [ADDR_W-1:0]               half;
   logic [ADDR_W-1:0]               last_m_calc;
   logic [dfir_pkg::RATIO_W-1:0]    ratio_eff;
   logic [PH_W-1:0]                 phase_inc;
   logic                            phase_wrap;
   logic                            warming;
   logic                            emit_go;
   logic                            live;
   logic [IXW-1:0]                  idx_ext;

   assign idle        = (state_ff == dfir_pkg::ST_IDLE);
   assign take_sample = idle && req_valid && !req_type;
   assign take_coef   = idle && req_valid && req_type;

   // Zero taps act as one, more than the memory holds act as the maximum.
   assign taps_ext    = CLW'(taps_in_use);
   assign taps_eff    = (taps_ext == '0) ? CLW'(1) :
                        (taps_ext > CLW'(MAX_TAPS)) ? CLW'(MAX_TAPS) : taps_ext;
   assign half        = ADDR_W'((taps_eff - CLW'(1)) >> 1);
   assign last_m_calc = ADDR_W'(taps_eff - CLW'(1));

   assign ratio_eff   = (decim_ratio == '0) ? dfir_pkg::RATIO_W'(1) : decim_ratio;
   assign phase_inc   = {1'b0, phase_ff} + PH_W'(1);
   assign phase_wrap  = (phase_inc >= {1'b0, ratio_eff});

   assign warming     = (warm_ff < half);
   assign emit_go     = take_sample && !warming && (phase_ff == '0);

   // Entries further back than the number of samples seen read as zero.
   assign live        = (TAPS_W'(m_ff) < fill_ff);

   assign idx_ext     = IXW'(req_coef_index);

   assign samp_we     = take_sample;
   assign samp_waddr  = wp_ff;
   assign samp_raddr  = rd_ptr_ff;
   assign coef_we     = take_coef && (idx_ext < IXW'(MAX_TAPS));
   assign coef_waddr  = idx_ext[ADDR_W-1:0];
   assign coef_raddr  = m_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfir_pkg::ST_IDLE: begin
            if (emit_go) state_in = dfir_pkg::ST_MAC;
         end
         dfir_pkg::ST_MAC: begin
            if (m_ff == last_m_ff) state_in = dfir_pkg::ST_DRAIN;
         end
         dfir_pkg::ST_DRAIN: begin
            if (dr_ff == DRAIN_LAST) state_in = dfir_pkg::ST_SCALE;
         end
         dfir_pkg::ST_SCALE: begin
            if (scale_last) state_in = dfir_pkg::ST_EMIT;
         end
         dfir_pkg::ST_EMIT: begin
            if (out_free) state_in = dfir_pkg::ST_IDLE;
         end
         default: begin
            state_in = dfir_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = !idle;
      ctl       = '0;
      ctl.clear = emit_go;
      ctl.issue = (state_ff == dfir_pkg::ST_MAC);
      ctl.live  = live;
      ctl.scale = (state_ff == dfir_pkg::ST_SCALE);
      ctl.emit  = (state_ff == dfir_pkg::ST_EMIT);
   end

   always_comb begin
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      warm_in   = warm_ff;
      phase_in  = phase_ff;
      m_in      = m_ff;
      last_m_in = last_m_ff;
      rd_ptr_in = rd_ptr_ff;
      dr_in     = dr_ff;
      if (take_sample) begin
         wp_in = (wp_ff == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_ff + 1'b1;
         if (fill_ff != TAPS_W'(MAX_TAPS)) begin
            fill_in = fill_ff + 1'b1;
         end
         if (warming) begin
            warm_in = warm_ff + 1'b1;
         end else begin
            phase_in = phase_wrap ? '0 : phase_inc[dfir_pkg::RATIO_W-1:0];
         end
      end
      if (emit_go) begin
         m_in      = '0;
         last_m_in = last_m_calc;
         rd_ptr_in = wp_ff;
      end
      if (state_ff == dfir_pkg::ST_MAC) begin
         m_in      = m_ff + 1'b1;
         rd_ptr_in = (rd_ptr_ff == '0) ? ADDR_W'(MAX_TAPS - 1) : rd_ptr_ff - 1'b1;
         dr_in     = '0;
      end
      if (state_ff == dfir_pkg::ST_DRAIN) begin
         dr_in = dr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dfir_pkg::ST_IDLE;
         wp_ff     <= '0;
         fill_ff   <= '0;
         warm_ff   <= '0;
         phase_ff  <= '0;
         m_ff      <= '0;
         last_m_ff <= '0;
         rd_ptr_ff <= '0;
         dr_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         warm_ff   <= warm_in;
         phase_ff  <= phase_in;
         m_ff      <= m_in;
         last_m_ff <= last_m_in;
         rd_ptr_ff <= rd_ptr_in;
         dr_ff     <= dr_in;
      end
   end

endmodule

FILE: hw/rtl/dfir_mac.sv
// ----------------------------------------------------------------------------
// dfir_mac: multiply-accumulate and output scaling datapath
// Accumulates coefficient times sample over the taps, multiplies the sum by
// the gain chunk by chunk, then rounds and saturates to a sample.
// ----------------------------------------------------------------------------
module dfir_mac #(
   parameter int MAX_TAPS    = dfir_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = dfir_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = dfir_pkg::COEF_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dfir_pkg::mac_ctl_type               ctl,
   input  logic signed [COEF_BITS-1:0]         coef_rdata,
   input  logic signed [SAMPLE_BITS-1:0]       samp_rdata,
   input  logic [dfir_pkg::GAIN_W-1:0]         out_gain,
   output logic                                scale_last,
   output logic [SAMPLE_BITS-1:0]              res_sample,
   output logic                                res_saturated
);

   localparam int ADDR_W = $clog2(MAX_TAPS);
   localparam int MUL_W  = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W  = SAMPLE_BITS + COEF_BITS + ADDR_W;
   localparam int NCH    = (ACC_W + dfir_pkg::CHUNK_W - 1) / dfir_pkg::CHUNK_W;
   localparam int EXT_W  = NCH * dfir_pkg::CHUNK_W;
   localparam int CH_W   = $clog2(NCH);
   localparam int SCL_W  = dfir_pkg::CHUNK_W + dfir_pkg::GAIN_W + 2;
   localparam int PROD_W = EXT_W + dfir_pkg::GAIN_W + 2;
   localparam int SH     = COEF_BITS + 14;
   localparam int Y_W    = PROD_W - SH;
   localparam logic [CH_W-1:0] CH_LAST = CH_W'(NCH - 1);

   logic                               rd_vld_ff;
   logic                               rd_live_ff;
   logic                               prod_vld_ff;
   logic [CH_W-1:0]                    ch_ff, ch_in;
   logic signed [MUL_W-1:0]            tap_prod_ff, tap_prod_in;
   logic signed [ACC_W-1:0]            acc_ff, acc_in;
   logic signed [PROD_W-1:0]           prod_ff, prod_in;

   logic signed [SAMPLE_BITS-1:0]      samp_eff;
   logic signed [EXT_W-1:0]            acc_ext;
   logic [dfir_pkg::CHUNK_W-1:0]       chunk;
   logic                               first;
   logic signed [dfir_pkg::CHUNK_W:0]  mul_a;
   logic signed [dfir_pkg::GAIN_W:0]   mul_b;
   logic signed [SCL_W-1:0]            scl_mul;
   logic signed [PROD_W-1:0]           rnd;
   logic signed [Y_W-1:0]              y;
   logic                               fits;

   // Tap product: a slot beyond the stream start contributes zero.
   assign samp_eff    = rd_live_ff ? samp_rdata : '0;
   assign tap_prod_in = coef_rdata * samp_eff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(tap_prod_ff);
      end
   end

   // Gain multiply, most significant chunk first (Horner form).
   assign acc_ext = EXT_W'(acc_ff);
   assign chunk   = acc_ext[ch_ff * dfir_pkg::CHUNK_W +: dfir_pkg::CHUNK_W];
   assign first   = (ch_ff == CH_LAST);
   assign mul_a   = first ? {chunk[dfir_pkg::CHUNK_W-1], chunk} : {1'b0, chunk};
   assign mul_b   = {1'b0, out_gain};
   assign scl_mul = mul_a * mul_b;

   always_comb begin
      prod_in = prod_ff;
      if (ctl.scale) begin
         if (first) begin
            prod_in = PROD_W'(scl_mul);
         end else begin
            prod_in = (prod_ff <<< dfir_pkg::CHUNK_W) + PROD_W'(scl_mul);
         end
      end
   end

   always_comb begin
      ch_in = ch_ff;
      if (ctl.clear) begin
         ch_in = CH_LAST;
      end else if (ctl.scale) begin
         ch_in = ch_ff - 1'b1;
      end
   end

   assign scale_last = (ch_ff == '0);

   // Round half up, then clip to the sample range.
   assign rnd  = prod_ff + (PROD_W'(1) <<< (SH - 1));
   assign y    = rnd[PROD_W-1:SH];
   assign fits = (&y[Y_W-1:SAMPLE_BITS-1]) || !(|y[Y_W-1:SAMPLE_BITS-1]);

   assign res_saturated = !fits;
   assign res_sample    = fits ? y[SAMPLE_BITS-1:0] :
                          y[Y_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                                     {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         rd_live_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         ch_ff       <= CH_LAST;
      end else begin
         rd_vld_ff   <= ctl.issue;
         rd_live_ff  <= ctl.issue && ctl.live;
         prod_vld_ff <= rd_vld_ff;
         ch_ff       <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_prod_ff <= tap_prod_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
   end

endmodule

FILE: hw/rtl/decimating_fir_filter_core.sv
// ----------------------------------------------------------------------------
// decimating_fir_filter_core: downsampling FIR low-pass filter
// Usage: requests on the req_ channel are either audio samples (req_type 0)
// or coefficient loads (req_type 1, tap req_coef_index). A request is taken
// when req_valid is high and req_stall is low. Sample requests enter a
// circular delay line; one of every decim_ratio samples, once warmup is
// over, produces a filtered sample on the rsp_ channel, taken when
// rsp_valid is high and rsp_stall is low. Loads and other samples produce
// nothing and leave the core idle, ready for the next request.
// A producing sample walks the taps, one tap per cycle, through the single
// multiply-accumulate unit and the two memory read ports, drains the
// pipeline, takes one gain step per 16-bit accumulator chunk, then goes
// into the output register.
// Reset clears the counters, the delay-line fill level and the registers to
// their defaults; the delay line needs no clearing pass. A result held by a
// stalled receiver stays put; the core takes requests until a producing
// sample arrives, then stalls until that result enters the output register.
// Registers (csr_index): 0 decim_ratio, 1 taps_in_use, 2 out_gain. Write
// them only while no request is in flight.
// ----------------------------------------------------------------------------
module decimating_fir_filter_core #(
   parameter int MAX_TAPS    = dfir_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = dfir_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = dfir_pkg::COEF_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   input  logic [dfir_pkg::COEF_INDEX_W-1:0]   req_coef_index,
   input  logic signed [COEF_BITS-1:0]         req_coef_value,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic                                rsp_saturated,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dfir_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dfir_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_TAPS);

   // Configuration registers.
   logic [dfir_pkg::RATIO_W-1:0]     ratio_ff, ratio_in;
   logic [dfir_pkg::TAPS_REG_W-1:0]  taps_ff, taps_in;
   logic [dfir_pkg::GAIN_W-1:0]      gain_ff, gain_in;

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]           rsp_sample_ff;
   logic                             rsp_sat_ff;

   logic                             out_free;
   logic                             rsp_load;
   logic                             scale_last;
   dfir_pkg::mac_ctl_type            ctl;

   logic                             samp_we;
   logic [ADDR_W-1:0]                samp_waddr;
   logic [ADDR_W-1:0]                samp_raddr;
   logic [SAMPLE_BITS-1:0]           samp_rdata;
   logic                             coef_we;
   logic [ADDR_W-1:0]                coef_waddr;
   logic [ADDR_W-1:0]                coef_raddr;
   logic [COEF_BITS-1:0]             coef_rdata;
   logic [SAMPLE_BITS-1:0]           res_sample;
   logic                             res_saturated;

   // The register file never holds off a write.
   assign csr_ready = 1'b1;

   always_comb begin
      ratio_in = ratio_ff;
      taps_in  = taps_ff;
      gain_in  = gain_ff;
      if (csr_valid) begin
         unique case (dfir_pkg::csr_index_type'(csr_index))
            dfir_pkg::CSR_DECIM_RATIO: ratio_in = csr_wdata[dfir_pkg::RATIO_W-1:0];
            dfir_pkg::CSR_TAPS_IN_USE: taps_in  = csr_wdata[dfir_pkg::TAPS_REG_W-1:0];
            dfir_pkg::CSR_OUT_GAIN:    gain_in  = csr_wdata[dfir_pkg::GAIN_W-1:0];
            default: begin
               // Writes to an unused index are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= dfir_pkg::DECIM_RATIO_RST;
         taps_ff  <= dfir_pkg::TAPS_RST;
         gain_ff  <= dfir_pkg::GAIN_RST;
      end else begin
         ratio_ff <= ratio_in;
         taps_ff  <= taps_in;
         gain_ff  <= gain_in;
      end
   end

   // The output register takes a new result when it is empty or being drained.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_load     = ctl.emit && out_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= res_sample;
         rsp_sat_ff    <= res_saturated;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

   dfir_ctrl #(
      .MAX_TAPS (MAX_TAPS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_type       (req_type),
      .req_coef_index (req_coef_index),
      .decim_ratio    (ratio_ff),
      .taps_in_use    (taps_ff),
      .scale_last     (scale_last),
      .out_free       (out_free),
      .req_stall      (req_stall),
      .samp_we        (samp_we),
      .samp_waddr     (samp_waddr),
      .samp_raddr     (samp_raddr),
      .coef_we        (coef_we),
      .coef_waddr     (coef_waddr),
      .coef_raddr     (coef_raddr),
      .ctl            (ctl)
   );

   // Delay line: the sample is written at acceptance, before any tap read.
   dfir_ram #(
      .DEPTH (MAX_TAPS),
      .WIDTH (SAMPLE_BITS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (samp_we),
      .wr_addr (samp_waddr),
      .wr_data (req_sample_in),
      .rd_addr (samp_raddr),
      .rd_data (samp_rdata)
   );

   // Coefficient table: loads only arrive while the tap walk is idle.
   dfir_ram #(
      .DEPTH (MAX_TAPS),
      .WIDTH (COEF_BITS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_coef_value),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   dfir_mac #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .coef_rdata    (coef_rdata),
      .samp_rdata    (samp_rdata),
      .out_gain      (gain_ff),
      .scale_last    (scale_last),
      .res_sample    (res_sample),
      .res_saturated (res_saturated)
   );

   // Scaling must not start before the last tap product has been summed.
   a_drain_before_scale: assert property (@(posedge clock) disable iff (reset)
      $rose(ctl.scale) |-> !$past(ctl.issue, 1) && !$past(ctl.issue, 2))
      else $error("gain multiply started with tap products in flight");

   // A result is offered only after the gain multiply has finished.
   a_emit_after_scale: assert property (@(posedge clock) disable iff (reset)
      $rose(ctl.emit) |-> $past(ctl.scale))
      else $error("result offered without a preceding gain multiply");

   // An accepted request never produces a result in the very next cycle.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_load)
      else $error("result loaded directly after a request");

endmodule
